>>> sv/ipdpe_pkg.sv
// ----------------------------------------------------------------------------
// ipdpe_pkg
// Shared types and codes for the int16 packed dot-product engine.
// ----------------------------------------------------------------------------
package ipdpe_pkg;

  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned ROW_W     = 6;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PCOUNT_W  = 8;

  localparam logic [OPCODE_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [PCOUNT_W-1:0] PAIR_COUNT_RESET = 8'd88;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  // Control from the sequencer to the multiply-accumulate pipe
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

endpackage

>>> sv/int16_packed_dot_product_engine.sv
// ----------------------------------------------------------------------------
// int16_packed_dot_product_engine
// Row stores for A and B of packed int16 pairs and a dual signed MAC walker.
// ----------------------------------------------------------------------------
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, opcode, row_sel,       | into block
//          | word_pos, b_row_sel, packed_word           |
//  out     | out_valid, out_stall, a_row_out,           | out of block
//          | b_row_out, dot_value                       |
//  cfg     | cfg_wr_en, cfg_wr_data (pair_count)        | into block
//
//  A write item leaves the block idle; it is ready again on the next cycle.
//  A compute item reads n = min(pair_count, MAX_PAIRS) words, drains the
//  MAC pipe and loads its result: each row store reads one word per cycle.
//  rst clears control state and sets pair_count to 88; the stores are not
//  cleared. A stalled result holds in the output register; write items are
//  still taken meanwhile, and a following compute waits only at its end.
//
module int16_packed_dot_product_engine #(
  parameter int unsigned MAX_A_ROWS = 64,
  parameter int unsigned MAX_B_ROWS = 64,
  parameter int unsigned MAX_PAIRS  = 128
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ipdpe_pkg::OPCODE_W-1:0]        opcode,
  input  logic [ipdpe_pkg::ROW_W-1:0]           row_sel,
  input  logic [ipdpe_pkg::POS_W-1:0]           word_pos,
  input  logic [ipdpe_pkg::ROW_W-1:0]           b_row_sel,
  input  logic [ipdpe_pkg::WORD_W-1:0]          packed_word,
  // result items
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ipdpe_pkg::ROW_W-1:0]           a_row_out,
  output logic [ipdpe_pkg::ROW_W-1:0]           b_row_out,
  output logic signed [ipdpe_pkg::WORD_W-1:0]   dot_value,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [ipdpe_pkg::PCOUNT_W-1:0]        cfg_wr_data
);

  localparam int unsigned A_DEPTH = MAX_A_ROWS * MAX_PAIRS;
  localparam int unsigned B_DEPTH = MAX_B_ROWS * MAX_PAIRS;
  localparam int unsigned A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int unsigned B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_PAIRS + 1);

  // Row stores
  logic [ipdpe_pkg::WORD_W-1:0] a_mem [A_DEPTH];
  logic [ipdpe_pkg::WORD_W-1:0] b_mem [B_DEPTH];
  logic [ipdpe_pkg::WORD_W-1:0] a_rd;
  logic [ipdpe_pkg::WORD_W-1:0] b_rd;

  // Configuration
  logic [ipdpe_pkg::PCOUNT_W-1:0] pair_count;

  // Sequencer
  ipdpe_pkg::state_t state;
  ipdpe_pkg::state_t state_next;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  n_words;
  logic [A_AW-1:0]   a_base;
  logic [B_AW-1:0]   b_base;
  logic [ipdpe_pkg::ROW_W-1:0] a_row;
  logic [ipdpe_pkg::ROW_W-1:0] b_row;
  logic              rd_vld;

  // Decoded controls
  logic              in_take;
  logic              take_cmp;
  logic              wr_a;
  logic              wr_b;
  logic              rd_en;
  logic              out_free;
  logic              load_out;
  logic              rows_ok;
  logic [CNT_W-1:0]  n_clamp;
  logic [A_AW-1:0]   wr_a_addr;
  logic [B_AW-1:0]   wr_b_addr;

  ipdpe_pkg::mac_ctl_t                 mac_ctl;
  logic signed [ipdpe_pkg::WORD_W-1:0] mac_acc;
  logic                                mac_busy;

  // ---------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------
  assign in_take  = in_valid & ~in_stall;
  assign take_cmp = in_take & (opcode == ipdpe_pkg::OP_COMPUTE);

  // Drop writes that fall outside the stores
  assign wr_a = in_take & (opcode == ipdpe_pkg::OP_WRITE_A) &
                (32'(row_sel) < MAX_A_ROWS) & (32'(word_pos) < MAX_PAIRS);
  assign wr_b = in_take & (opcode == ipdpe_pkg::OP_WRITE_B) &
                (32'(row_sel) < MAX_B_ROWS) & (32'(word_pos) < MAX_PAIRS);

  assign wr_a_addr = A_AW'(32'(row_sel) * MAX_PAIRS + 32'(word_pos));
  assign wr_b_addr = B_AW'(32'(row_sel) * MAX_PAIRS + 32'(word_pos));

  // A row out of range reads as zeros: walk no words at all
  assign rows_ok = (32'(row_sel) < MAX_A_ROWS) & (32'(b_row_sel) < MAX_B_ROWS);
  assign n_clamp = (32'(pair_count) > MAX_PAIRS) ? CNT_W'(MAX_PAIRS)
                                                 : CNT_W'(pair_count);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= ipdpe_pkg::PAIR_COUNT_RESET;
    end else if (cfg_wr_en) begin
      pair_count <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------
  // Row stores: written while idle, read while walking a row
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[wr_a_addr] <= packed_word;
    end
    a_rd <= a_mem[a_base + A_AW'(idx)];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      b_mem[wr_b_addr] <= packed_word;
    end
    b_rd <= b_mem[b_base + B_AW'(idx)];
  end

  // ---------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ipdpe_pkg::S_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (take_cmp) begin
      idx     <= '0;
      n_words <= rows_ok ? n_clamp : '0;
      a_base  <= A_AW'(32'(row_sel) * MAX_PAIRS);
      b_base  <= B_AW'(32'(b_row_sel) * MAX_PAIRS);
      a_row   <= row_sel;
      b_row   <= b_row_sel;
    end else if (rd_en) begin
      idx <= idx + CNT_W'(1);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ipdpe_pkg::S_IDLE: begin
        if (take_cmp) begin
          state_next = ipdpe_pkg::S_RUN;
        end
      end
      ipdpe_pkg::S_RUN: begin
        if (idx == n_words) begin
          state_next = ipdpe_pkg::S_DRAIN;
        end
      end
      ipdpe_pkg::S_DRAIN: begin
        if (!rd_vld && !mac_busy) begin
          state_next = ipdpe_pkg::S_DONE;
        end
      end
      ipdpe_pkg::S_DONE: begin
        if (out_free) begin
          state_next = ipdpe_pkg::S_IDLE;
        end
      end
      default: state_next = ipdpe_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  assign out_free = ~out_valid | ~out_stall;

  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    load_out = 1'b0;
    case (state)
      ipdpe_pkg::S_IDLE:  in_stall = 1'b0;
      ipdpe_pkg::S_RUN:   rd_en    = (idx != n_words);
      ipdpe_pkg::S_DRAIN: in_stall = 1'b1;
      ipdpe_pkg::S_DONE:  load_out = out_free;
      default:            in_stall = 1'b1;
    endcase
  end

  assign mac_ctl.clear = take_cmp;
  assign mac_ctl.valid = rd_vld;

  // ---------------------------------------------------------------------
  // Dual multiply-accumulate
  // ---------------------------------------------------------------------
  ipdpe_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .a_word (a_rd),
    .b_word (b_rd),
    .acc    (mac_acc),
    .busy   (mac_busy)
  );

  // ---------------------------------------------------------------------
  // Output register: hold the result until it is taken
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      a_row_out <= a_row;
      b_row_out <= b_row;
      dot_value <= mac_acc;
    end
  end

endmodule

>>> sv/ipdpe_mac.sv
// ----------------------------------------------------------------------------
// ipdpe_mac
// Dual signed 16x16 multiply-accumulate pipe: products, pair sum, accumulate.
// ----------------------------------------------------------------------------
module ipdpe_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  ipdpe_pkg::mac_ctl_t                 ctl,
  input  logic [ipdpe_pkg::WORD_W-1:0]        a_word,
  input  logic [ipdpe_pkg::WORD_W-1:0]        b_word,
  output logic signed [ipdpe_pkg::WORD_W-1:0] acc,
  output logic                                busy
);

  logic                                prod_vld;
  logic                                sum_vld;
  logic signed [ipdpe_pkg::WORD_W-1:0] prod_lo;
  logic signed [ipdpe_pkg::WORD_W-1:0] prod_hi;
  logic signed [ipdpe_pkg::WORD_W-1:0] pair_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      sum_vld  <= 1'b0;
    end else begin
      prod_vld <= ctl.valid;
      sum_vld  <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_lo  <= 32'($signed(a_word[15:0])) * 32'($signed(b_word[15:0]));
    prod_hi  <= 32'($signed(a_word[31:16])) * 32'($signed(b_word[31:16]));
    pair_sum <= prod_lo + prod_hi;
  end

  // Clear arrives while the pipe is empty
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (sum_vld) begin
      acc <= acc + pair_sum;
    end
  end

  assign busy = prod_vld | sum_vld;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the int16 packed dot-product engine. It fills the
// A and B row stores with packed int16 pairs and requests dot products over
// several pair counts. Both channels stall and idle at random, and every
// result is checked field by field against a bit-accurate predictor.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned A_ROWS = 64;
  localparam int unsigned B_ROWS = 64;
  localparam int unsigned PAIRS = 128;
  localparam int unsigned CLK_PERIOD = 12;
  localparam int unsigned RESET_CYCLES = 7;
  // Opcode 3 has no function in the block; it is sent as noise.
  localparam logic [ipdpe_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  // A write is stored at the edge that takes it; give some margin.
  localparam int unsigned PHASE_SETTLE = 16;
  // At the end, cover the longest compute, over PAIRS words, and then some.
  localparam int unsigned END_SETTLE = PAIRS + 20;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned RANDOM_ITEMS = 150;
  localparam longint unsigned TIMEOUT_CYCLES = 800_000;

  // One input item as the sender presents it.
  typedef struct {
    logic [ipdpe_pkg::OPCODE_W-1:0] opcode;
    logic [ipdpe_pkg::ROW_W-1:0]    row;
    logic [ipdpe_pkg::POS_W-1:0]    pos;
    logic [ipdpe_pkg::ROW_W-1:0]    brow;
    logic [ipdpe_pkg::WORD_W-1:0]   word;
    bit                             drain_first;  // hold back until no result is due
  } request_t;

  // One expected dot-product result.
  typedef struct {
    logic [ipdpe_pkg::ROW_W-1:0]  a_row;
    logic [ipdpe_pkg::ROW_W-1:0]  b_row;
    logic [ipdpe_pkg::WORD_W-1:0] dot;
  } dot_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [ipdpe_pkg::OPCODE_W-1:0]      opcode = '0;
  logic [ipdpe_pkg::ROW_W-1:0]         row_sel = '0;
  logic [ipdpe_pkg::POS_W-1:0]         word_pos = '0;
  logic [ipdpe_pkg::ROW_W-1:0]         b_row_sel = '0;
  logic [ipdpe_pkg::WORD_W-1:0]        packed_word = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [ipdpe_pkg::ROW_W-1:0]         a_row_out;
  logic [ipdpe_pkg::ROW_W-1:0]         b_row_out;
  logic signed [ipdpe_pkg::WORD_W-1:0] dot_value;
  logic                                cfg_wr_en = 1'b0;
  logic [ipdpe_pkg::PCOUNT_W-1:0]      cfg_wr_data = '0;

  // Predictor state: its own copy of both stores and of the pair count.
  logic [ipdpe_pkg::WORD_W-1:0]   a_rows [A_ROWS][PAIRS];
  logic [ipdpe_pkg::WORD_W-1:0]   b_rows [B_ROWS][PAIRS];
  logic [ipdpe_pkg::PCOUNT_W-1:0] pair_setting = ipdpe_pkg::PAIR_COUNT_RESET;
  dot_result_t                    dots_due [$];

  // Stimulus side: which store words hold data, and the items still to send.
  bit       a_written [A_ROWS][PAIRS];
  bit       b_written [B_ROWS][PAIRS];
  request_t requests [$];
  int       item_count = 0;
  int       error_count = 0;

  // Sender state
  request_t next_req;
  bit       staged = 1'b0;     // an item is popped and counting down its gap
  bit       offering = 1'b0;   // mirror of in_valid, current within the step
  bit       in_took = 1'b0;    // the item on offer was taken at the last edge
  int       gap_left = 0;
  int       send_calm = 0;

  // Receiver state
  bit       res_took = 1'b0;
  bit       res_blocked = 1'b0;
  int       hold_left = 0;
  int       recv_calm = 0;

  int16_packed_dot_product_engine #(
    .MAX_A_ROWS(A_ROWS),
    .MAX_B_ROWS(B_ROWS),
    .MAX_PAIRS (PAIRS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .row_sel    (row_sel),
    .word_pos   (word_pos),
    .b_row_sel  (b_row_sel),
    .packed_word(packed_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .a_row_out  (a_row_out),
    .b_row_out  (b_row_out),
    .dot_value  (dot_value),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Draw the wait before the next item: mostly a uniform random gap, with runs of
  // back-to-back items now and then so both busy and sparse traffic occur.
  function automatic int draw_pause(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Packed word with each int16 half biased toward min, max, -1 and zero.
  function automatic logic [ipdpe_pkg::WORD_W-1:0] rand_word();
    logic [15:0] half [2];
    int          h;
    for (h = 0; h < 2; h++) begin
      case ($urandom_range(0, 7))
        0: half[h] = 16'h8000;
        1: half[h] = 16'h7FFF;
        2: half[h] = 16'hFFFF;
        3: half[h] = 16'h0000;
        default: half[h] = 16'($urandom);
      endcase
    end
    return {half[1], half[0]};
  endfunction

  // Dual signed 16x16 multiply-accumulate over the first min(pair count,
  // PAIRS) words of the two rows; the sum wraps at 32 bits.
  function automatic logic [ipdpe_pkg::WORD_W-1:0] dot_of(int unsigned a_idx,
                                                          int unsigned b_idx);
    logic [ipdpe_pkg::WORD_W-1:0]        acc;
    logic signed [15:0]                  a_lo, a_hi, b_lo, b_hi;
    logic signed [ipdpe_pkg::WORD_W-1:0] p_lo, p_hi;
    int unsigned                         n, k;
    acc = '0;
    n = (pair_setting > PAIRS) ? PAIRS : pair_setting;
    // Rows beyond the store read as zero words, so they add nothing.
    if (a_idx < A_ROWS && b_idx < B_ROWS) begin
      for (k = 0; k < n; k++) begin
        a_lo = a_rows[a_idx][k][15:0];
        a_hi = a_rows[a_idx][k][31:16];
        b_lo = b_rows[b_idx][k][15:0];
        b_hi = b_rows[b_idx][k][31:16];
        p_lo = a_lo * b_lo;
        p_hi = a_hi * b_hi;
        acc = acc + p_lo + p_hi;
      end
    end
    return acc;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic push_request(input logic [ipdpe_pkg::OPCODE_W-1:0] op,
                              input int unsigned row,
                              input int unsigned pos, input int unsigned brow,
                              input logic [ipdpe_pkg::WORD_W-1:0] word, input bit drain);
    request_t r;
    r.opcode = op;
    r.row = ipdpe_pkg::ROW_W'(row);
    r.pos = ipdpe_pkg::POS_W'(pos);
    r.brow = ipdpe_pkg::ROW_W'(brow);
    r.word = word;
    r.drain_first = drain;
    requests.push_back(r);
    if (op != OP_UNUSED) item_count++;
  endtask

  task automatic store_word(input logic [ipdpe_pkg::OPCODE_W-1:0] op,
                            input int unsigned row, input int unsigned pos,
                            input logic [ipdpe_pkg::WORD_W-1:0] word);
    // b_row_sel is ignored by writes; keep it moving anyway.
    push_request(op, row, pos, $urandom_range(0, B_ROWS - 1), word, 1'b0);
    if (op == ipdpe_pkg::OP_WRITE_A) a_written[row][pos] = 1'b1;
    else b_written[row][pos] = 1'b1;
  endtask

  // Fill any word of the two rows that the compute will read and that has
  // never been written, then ask for the dot product.
  task automatic dot_request(input int unsigned a_idx, input int unsigned b_idx,
                             input bit drain);
    int unsigned n, k;
    n = (pair_setting > PAIRS) ? PAIRS : pair_setting;
    for (k = 0; k < n; k++) begin
      if (!a_written[a_idx][k]) store_word(ipdpe_pkg::OP_WRITE_A, a_idx, k, rand_word());
      if (!b_written[b_idx][k]) store_word(ipdpe_pkg::OP_WRITE_B, b_idx, k, rand_word());
    end
    push_request(ipdpe_pkg::OP_COMPUTE, a_idx, $urandom_range(0, PAIRS - 1), b_idx,
                 $urandom, drain);
  endtask

  // Wait until every item is sent and every result is in, then let the
  // block settle. Runs on the falling edge, where the sender state is final.
  task automatic wait_idle(input int unsigned settle);
    do @(negedge clk);
    while (requests.size() != 0 || staged || offering || dots_due.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // Called at a falling edge while the block is idle.
  task automatic set_pair_count(input logic [ipdpe_pkg::PCOUNT_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    pair_setting = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sender: present the queued items on the falling edge, each after its own
  // gap. Hold the payload while stalled; in_valid gets one update per edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      offering = 1'b0;
      staged = 1'b0;
      in_took = 1'b0;
    end else begin
      if (in_took) begin
        in_took = 1'b0;
        offering = 1'b0;
      end
      if (!offering) begin
        if (!staged && requests.size() != 0) begin
          next_req = requests.pop_front();
          staged = 1'b1;
          gap_left = draw_pause(send_calm);
        end
        if (staged) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!next_req.drain_first || dots_due.size() == 0) begin
            opcode <= next_req.opcode;
            row_sel <= next_req.row;
            word_pos <= next_req.pos;
            b_row_sel <= next_req.brow;
            packed_word <= next_req.word;
            offering = 1'b1;
            staged = 1'b0;
          end
        end
      end
    end
    in_valid <= offering;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall each result for a freshly drawn number of cycles. Count
  // down only on edges where a result was actually held back.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      hold_left = 0;
    end else if (res_took) begin
      hold_left = draw_pause(recv_calm);
    end else if (res_blocked && hold_left > 0) begin
      hold_left--;
    end
    res_took = 1'b0;
    res_blocked = 1'b0;
    out_stall <= (hold_left != 0);
  end

  // --------------------------------------------------------------------------
  // Monitor: on the rising edge, apply every taken item to the predictor and
  // check every taken result against the oldest expected one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    dot_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        case (opcode)
          ipdpe_pkg::OP_WRITE_A: begin
            if (row_sel < A_ROWS && word_pos < PAIRS) a_rows[row_sel][word_pos] = packed_word;
          end
          ipdpe_pkg::OP_WRITE_B: begin
            if (row_sel < B_ROWS && word_pos < PAIRS) b_rows[row_sel][word_pos] = packed_word;
          end
          ipdpe_pkg::OP_COMPUTE: begin
            want.a_row = row_sel;
            want.b_row = b_row_sel;
            want.dot = dot_of(row_sel, b_row_sel);
            dots_due.push_back(want);
          end
          default: ;  // unused opcode: drop it
        endcase
      end
      if (out_valid && !out_stall) begin
        res_took = 1'b1;
        if (dots_due.size() == 0) begin
          report_error($sformatf("result with none due: a_row %0d b_row %0d dot %0d",
                                 a_row_out, b_row_out, dot_value));
        end else begin
          want = dots_due.pop_front();
          if (a_row_out !== want.a_row)
            report_error($sformatf("a_row_out got %0d want %0d", a_row_out, want.a_row));
          if (b_row_out !== want.b_row)
            report_error($sformatf("b_row_out got %0d want %0d", b_row_out, want.b_row));
          if (dot_value !== want.dot)
            report_error($sformatf("dot_value got %0d want %0d (a_row %0d b_row %0d)",
                                   dot_value, $signed(want.dot), want.a_row, want.b_row));
        end
      end else if (out_valid) begin
        res_blocked = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, phase by phase; the pair count changes only between phases.
  // --------------------------------------------------------------------------
  initial begin
    logic [ipdpe_pkg::WORD_W-1:0] corner_a [5] = '{32'h8000_8000, 32'h7FFF_7FFF,
                                                   32'hFFFF_FFFF, 32'h7FFF_0001,
                                                   32'h0000_0000};
    logic [ipdpe_pkg::WORD_W-1:0] corner_b [5] = '{32'h8000_8000, 32'h8000_8000,
                                                   32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                                   32'hFFFF_FFFF};
    int unsigned corner_ar [5] = '{0, 63, 63, 0, 31};
    int unsigned corner_br [5] = '{63, 0, 63, 0, 32};
    int unsigned hot_a [3];
    int unsigned hot_b [3];
    int unsigned i, p, target, sel, a_pick, b_pick;
    bit          first;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset pair count (88): fill A row 0 and B row 63, put min*min in the
    // last word used, and pause once for every result before the compute.
    dot_request(0, 63, 1'b0);
    store_word(ipdpe_pkg::OP_WRITE_A, 0, 87, 32'h8000_8000);
    store_word(ipdpe_pkg::OP_WRITE_B, 63, 87, 32'h8000_8000);
    dot_request(0, 63, 1'b1);
    wait_idle(PHASE_SETTLE);

    // One pair: isolate the corner products, including the wrap of
    // (-32768 * -32768) * 2 to the most negative value.
    set_pair_count(8'd1);
    for (i = 0; i < 5; i++) begin
      store_word(ipdpe_pkg::OP_WRITE_A, corner_ar[i], 0, corner_a[i]);
      store_word(ipdpe_pkg::OP_WRITE_B, corner_br[i], 0, corner_b[i]);
      dot_request(corner_ar[i], corner_br[i], 1'b0);
    end
    store_word(ipdpe_pkg::OP_WRITE_A, A_ROWS - 1, PAIRS - 1, 32'hFFFF_FFFF);
    push_request(OP_UNUSED, A_ROWS - 1, PAIRS - 1, B_ROWS - 1, 32'hFFFF_FFFF, 1'b0);
    push_request(OP_UNUSED, 0, 0, 0, 32'h0000_0000, 1'b0);
    dot_request(A_ROWS - 1, B_ROWS - 1, 1'b0);
    wait_idle(PHASE_SETTLE);

    // Zero pairs: the result is zero and nothing is read, so any rows do.
    set_pair_count(8'd0);
    for (i = 0; i < 4; i++) begin
      dot_request($urandom_range(0, A_ROWS - 1), $urandom_range(0, B_ROWS - 1), 1'b0);
      store_word(ipdpe_pkg::OP_WRITE_B, $urandom_range(0, B_ROWS - 1),
                 $urandom_range(0, PAIRS - 1), rand_word());
    end
    wait_idle(PHASE_SETTLE);

    // All ones saturates to the full row: fill to word 127, then change it.
    set_pair_count(8'hFF);
    dot_request(0, 63, 1'b0);
    store_word(ipdpe_pkg::OP_WRITE_A, 0, PAIRS - 1, 32'h8000_8000);
    store_word(ipdpe_pkg::OP_WRITE_B, 63, PAIRS - 1, 32'h8000_8000);
    dot_request(0, 63, 1'b0);
    wait_idle(PHASE_SETTLE);

    // Exactly the full row.
    set_pair_count(8'(PAIRS));
    dot_request(0, 63, 1'b0);
    store_word(ipdpe_pkg::OP_WRITE_B, 63, 0, rand_word());
    dot_request(0, 63, 1'b0);
    wait_idle(PHASE_SETTLE);

    // Random phases: mostly fill-and-compute on a few hot rows, with stray
    // writes anywhere and unused opcodes mixed in. Keep pair counts small
    // except in the last phase.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) set_pair_count(8'($urandom_range(16, 24)));
      else set_pair_count(8'($urandom_range(1, 8)));
      for (i = 0; i < 3; i++) begin
        hot_a[i] = $urandom_range(0, A_ROWS - 1);
        hot_b[i] = $urandom_range(0, B_ROWS - 1);
      end
      target = item_count + RANDOM_ITEMS / RANDOM_PHASES;
      first = 1'b1;
      while (item_count < target) begin
        sel = $urandom_range(0, 19);
        if (sel < 11) begin
          a_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, A_ROWS - 1)
                                               : hot_a[$urandom_range(0, 2)];
          b_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, B_ROWS - 1)
                                               : hot_b[$urandom_range(0, 2)];
          dot_request(a_pick, b_pick, first || $urandom_range(0, 39) == 0);
          first = 1'b0;
        end else if (sel < 19) begin
          store_word($urandom_range(0, 1) ? ipdpe_pkg::OP_WRITE_B : ipdpe_pkg::OP_WRITE_A,
                     $urandom_range(0, A_ROWS - 1), $urandom_range(0, PAIRS - 1), rand_word());
        end else begin
          push_request(OP_UNUSED, $urandom_range(0, A_ROWS - 1), $urandom_range(0, PAIRS - 1),
                       $urandom_range(0, B_ROWS - 1), $urandom, 1'b0);
        end
      end
      wait_idle((p == RANDOM_PHASES - 1) ? END_SETTLE : PHASE_SETTLE);
    end

    if (error_count == 0 && dots_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
